FILE: rtl/msd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Morse symbol decoder package
// Symbol codes, the letter and digit code table, and the job record passed
// from the front end to the output side.
// ----------------------------------------------------------------------------
package msd_pkg;

   localparam int MAX_CODE_LEN_DEF = 5;
   localparam int JOB_QUEUE_DEPTH  = 2;

   localparam logic [2:0] SYM_DOT        = 3'd0;
   localparam logic [2:0] SYM_DASH       = 3'd1;
   localparam logic [2:0] SYM_LETTER_GAP = 3'd2;
   localparam logic [2:0] SYM_WORD_GAP   = 3'd3;
   localparam logic [2:0] SYM_END        = 3'd4;

   localparam logic [6:0] ERROR_CHAR_RESET = 7'd35;
   localparam logic [6:0] SPACE_CHAR       = 7'd32;

   typedef struct packed {
      logic       char_valid;
      logic [6:0] char_code;
      logic       add_space;
   } job_type;

   typedef struct packed {
      logic [2:0] len;
      logic [4:0] bits;
      logic [6:0] ch;
   } entry_type;

   localparam int MORSE_ENTRIES = 36;

   // Code bits: first symbol most significant, dot 0, dash 1.
   localparam entry_type MORSE_TABLE [MORSE_ENTRIES] = '{
      '{3'd2, 5'd1,  7'd65}, '{3'd4, 5'd8,  7'd66}, '{3'd4, 5'd10, 7'd67},
      '{3'd3, 5'd4,  7'd68}, '{3'd1, 5'd0,  7'd69}, '{3'd4, 5'd2,  7'd70},
      '{3'd3, 5'd6,  7'd71}, '{3'd4, 5'd0,  7'd72}, '{3'd2, 5'd0,  7'd73},
      '{3'd4, 5'd7,  7'd74}, '{3'd3, 5'd5,  7'd75}, '{3'd4, 5'd4,  7'd76},
      '{3'd2, 5'd3,  7'd77}, '{3'd2, 5'd2,  7'd78}, '{3'd3, 5'd7,  7'd79},
      '{3'd4, 5'd6,  7'd80}, '{3'd4, 5'd13, 7'd81}, '{3'd3, 5'd2,  7'd82},
      '{3'd3, 5'd0,  7'd83}, '{3'd1, 5'd1,  7'd84}, '{3'd3, 5'd1,  7'd85},
      '{3'd4, 5'd1,  7'd86}, '{3'd3, 5'd3,  7'd87}, '{3'd4, 5'd9,  7'd88},
      '{3'd4, 5'd11, 7'd89}, '{3'd4, 5'd12, 7'd90},
      '{3'd5, 5'd15, 7'd49}, '{3'd5, 5'd7,  7'd50}, '{3'd5, 5'd3,  7'd51},
      '{3'd5, 5'd1,  7'd52}, '{3'd5, 5'd0,  7'd53}, '{3'd5, 5'd16, 7'd54},
      '{3'd5, 5'd24, 7'd55}, '{3'd5, 5'd28, 7'd56}, '{3'd5, 5'd30, 7'd57},
      '{3'd5, 5'd31, 7'd48}
   };

   // Returns {hit, character}.
   function automatic logic [7:0] morse_lookup(input logic [3:0] len,
                                               input logic [7:0] bits);
      logic [7:0] res;
      res = '0;
      for (int i = 0; i < MORSE_ENTRIES; i++) begin
         if ({1'b0, MORSE_TABLE[i].len} == len &&
             {3'b000, MORSE_TABLE[i].bits} == bits) begin
            res = {1'b1, MORSE_TABLE[i].ch};
         end
      end
      return res;
   endfunction

endpackage

FILE: rtl/msd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Morse decoder front end
// Accepts symbols, collects the current code, resolves it on a gap and
// pushes a job for the output side.
// ----------------------------------------------------------------------------
module msd_front #(
   parameter int MAX_CODE_LEN = msd_pkg::MAX_CODE_LEN_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [2:0]       req_symbol,
   input  logic             csr_wr_en,
   input  logic [6:0]       csr_wr_data,
   input  logic             queue_full,
   output logic             push,
   output msd_pkg::job_type push_job
);
   import msd_pkg::*;

   localparam int LEN_W = $clog2(MAX_CODE_LEN + 1);

   logic [MAX_CODE_LEN-1:0] code_bits_ff, code_bits_in;
   logic [LEN_W-1:0]        code_length_ff, code_length_in;
   logic                    error_seen_ff, error_seen_in;
   logic [6:0]              error_char_ff;
   logic                    accept;
   logic                    have_code;
   logic [7:0]              lookup;

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;
   assign have_code = (code_length_ff != '0) || error_seen_ff;
   assign lookup    = morse_lookup({{(4 - LEN_W){1'b0}}, code_length_ff},
                                   {{(8 - MAX_CODE_LEN){1'b0}}, code_bits_ff});

   always_comb begin
      code_bits_in        = code_bits_ff;
      code_length_in      = code_length_ff;
      error_seen_in       = error_seen_ff;
      push                = 1'b0;
      push_job.char_valid = have_code;
      push_job.char_code  = (error_seen_ff || !lookup[7]) ? error_char_ff : lookup[6:0];
      push_job.add_space  = (req_symbol == SYM_WORD_GAP);
      if (accept) begin
         unique case (req_symbol)
            SYM_DOT, SYM_DASH: begin
               if (code_length_ff < LEN_W'(MAX_CODE_LEN)) begin
                  code_bits_in   = {code_bits_ff[MAX_CODE_LEN-2:0], req_symbol[0]};
                  code_length_in = code_length_ff + 1'b1;
               end else begin
                  error_seen_in = 1'b1;
               end
            end
            SYM_LETTER_GAP, SYM_WORD_GAP, SYM_END: begin
               push           = have_code || push_job.add_space;
               code_bits_in   = '0;
               code_length_in = '0;
               error_seen_in  = 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         code_bits_ff   <= '0;
         code_length_ff <= '0;
         error_seen_ff  <= 1'b0;
         error_char_ff  <= ERROR_CHAR_RESET;
      end else begin
         code_bits_ff   <= code_bits_in;
         code_length_ff <= code_length_in;
         error_seen_ff  <= error_seen_in;
         if (csr_wr_en) begin
            error_char_ff <= csr_wr_data;
         end
      end
   end

   a_error_at_full: assert property (@(posedge clock) disable iff (reset)
      error_seen_ff |-> (code_length_ff == LEN_W'(MAX_CODE_LEN)))
      else $error("overflow mark without a full code");

   a_length_bound: assert property (@(posedge clock) disable iff (reset)
      code_length_ff <= LEN_W'(MAX_CODE_LEN))
      else $error("code length beyond limit");

   a_clear_after_gap: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_symbol == SYM_LETTER_GAP || req_symbol == SYM_WORD_GAP ||
                  req_symbol == SYM_END)) |=> (code_length_ff == '0 && !error_seen_ff))
      else $error("code not cleared after gap");

endmodule

FILE: rtl/msd_job_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Morse decoder job queue
// Short FIFO between the front end and the output side.
// ----------------------------------------------------------------------------
module msd_job_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  msd_pkg::job_type push_job,
   output logic             full,
   input  logic             pop,
   output logic             head_valid,
   output msd_pkg::job_type head_job
);
   import msd_pkg::*;

   localparam int PTR_W = (JOB_QUEUE_DEPTH > 1) ? $clog2(JOB_QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(JOB_QUEUE_DEPTH + 1);

   job_type           slots_ff [JOB_QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   assign full       = (count_ff == CNT_W'(JOB_QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_job   = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(JOB_QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(JOB_QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      priority if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end else begin
         count_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_job;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("push into full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("pop from empty queue");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(JOB_QUEUE_DEPTH))
      else $error("queue count out of range");

endmodule

FILE: rtl/msd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Morse decoder output side
// Takes jobs from the queue and emits the character, then the space of a
// word gap, through a registered output stage.
// ----------------------------------------------------------------------------
module msd_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             head_valid,
   input  msd_pkg::job_type head_job,
   output logic             pop,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [6:0]       rsp_out_char,
   output logic             rsp_last_of_run
);
   import msd_pkg::*;

   logic       rsp_valid_ff, rsp_valid_in;
   logic [6:0] rsp_char_ff, rsp_char_in;
   logic       rsp_last_ff, rsp_last_in;
   logic       pending_space_ff, pending_space_in;
   logic       slot_free;

   assign slot_free       = !rsp_valid_ff || rsp_ready;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_char    = rsp_char_ff;
   assign rsp_last_of_run = rsp_last_ff;

   always_comb begin
      rsp_valid_in     = rsp_valid_ff && !rsp_ready;
      rsp_char_in      = rsp_char_ff;
      rsp_last_in      = rsp_last_ff;
      pending_space_in = pending_space_ff;
      pop              = 1'b0;
      if (slot_free) begin
         priority if (pending_space_ff) begin
            rsp_valid_in     = 1'b1;
            rsp_char_in      = SPACE_CHAR;
            rsp_last_in      = 1'b1;
            pending_space_in = 1'b0;
         end else if (head_valid) begin
            pop          = 1'b1;
            rsp_valid_in = 1'b1;
            if (head_job.char_valid) begin
               rsp_char_in      = head_job.char_code;
               rsp_last_in      = !head_job.add_space;
               pending_space_in = head_job.add_space;
            end else begin
               rsp_char_in = SPACE_CHAR;
               rsp_last_in = 1'b1;
            end
         end else begin
            rsp_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff     <= 1'b0;
         pending_space_ff <= 1'b0;
      end else begin
         rsp_valid_ff     <= rsp_valid_in;
         pending_space_ff <= pending_space_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   a_pending_shown: assert property (@(posedge clock) disable iff (reset)
      pending_space_ff |-> (rsp_valid_ff && !rsp_last_ff))
      else $error("pending space without its character on the output");

   a_no_pop_while_pending: assert property (@(posedge clock) disable iff (reset)
      pending_space_ff |-> !pop)
      else $error("job taken before space was sent");

   a_space_follows: assert property (@(posedge clock) disable iff (reset)
      (pending_space_ff && rsp_ready) |=>
         (rsp_valid_ff && rsp_last_ff && rsp_char_ff == SPACE_CHAR))
      else $error("space did not follow its character");

endmodule

FILE: rtl/morse_symbol_decoder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Morse symbol decoder
// Decodes dot, dash, letter gap, word gap and end of message symbols into
// uppercase ASCII letters and digits.
//
// req channel: one symbol per item (0 dot, 1 dash, 2 letter gap, 3 word gap,
// 4 end of message; 5 to 7 are ignored). An item is taken every cycle while
// the two-entry job queue has room.
// rsp channel: out_char and last_of_run. A letter gap or end of message with
// a held code gives one result; a word gap gives the character (if any code
// is held) and then a space. Codes that match no letter or digit, or that
// overflow the code length, give the csr error character (reset '#').
// A result goes through the job queue and then the output register after its
// closing symbol is taken. Throughput: one symbol per cycle in while the queue
// has room, one result per cycle out while the receiver is ready.
// When the receiver stalls, results wait in the output register and the job
// queue fills; req_ready drops once the queue is full.
// Reset clears the held code, the queue and the output, and sets the error
// character to '#'.
// ----------------------------------------------------------------------------
module morse_symbol_decoder_unit #(
   parameter int MAX_CODE_LEN = msd_pkg::MAX_CODE_LEN_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [2:0] req_symbol,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [6:0] rsp_out_char,
   output logic       rsp_last_of_run,
   input  logic       csr_wr_en,
   input  logic [6:0] csr_wr_data
);
   import msd_pkg::*;

   job_type push_job;
   job_type head_job;
   logic    push;
   logic    pop;
   logic    queue_full;
   logic    head_valid;

   msd_front #(
      .MAX_CODE_LEN(MAX_CODE_LEN)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_symbol (req_symbol),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .queue_full (queue_full),
      .push       (push),
      .push_job   (push_job)
   );

   msd_job_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_job  (push_job),
      .full      (queue_full),
      .pop       (pop),
      .head_valid(head_valid),
      .head_job  (head_job)
   );

   msd_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head_valid     (head_valid),
      .head_job       (head_job),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_char   (rsp_out_char),
      .rsp_last_of_run(rsp_last_of_run)
   );

endmodule

FILE: tb/tb_morse_symbol_decoder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Morse symbol decoder testbench
// Drives symbol items into the decoder and checks every decoded character
// against an in-bench decoder model. Directed cases cover known codes,
// unmatched and overlong codes, empty gaps and unused symbols. Random
// traffic is mostly whole codes with random closing gaps, mixed with noise.
// Traffic runs under three idle profiles and several error characters.
// ----------------------------------------------------------------------------
module tb_morse_symbol_decoder_unit;
   import msd_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES  = 4;
   localparam int DRAIN_CYCLES   = 8;

   typedef struct packed {
      logic [6:0] ch;
      logic       last;
   } char_result_type;

   logic       clock       = 1'b0;
   logic       reset       = 1'b1;
   logic       req_valid   = 1'b0;
   logic       req_ready;
   logic [2:0] req_symbol  = SYM_DOT;
   logic       rsp_valid;
   logic       rsp_ready   = 1'b0;
   logic [6:0] rsp_out_char;
   logic       rsp_last_of_run;
   logic       csr_wr_en   = 1'b0;
   logic [6:0] csr_wr_data = '0;

   // decoder model state
   logic [4:0] held_bits     = '0;
   logic [2:0] held_len      = '0;
   logic       held_overflow = 1'b0;
   logic [6:0] error_char_q  = ERROR_CHAR_RESET;

   char_result_type expected_chars[$];
   int fail_count     = 0;
   int idle_cycles    = 0;
   int send_idle_pct  = 0;
   int recv_idle_pct  = 0;

   morse_symbol_decoder_unit dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_symbol      (req_symbol),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_char    (rsp_out_char),
      .rsp_last_of_run (rsp_last_of_run),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // returns {hit, character}
   function automatic logic [7:0] code_to_char(input logic [2:0] len, input logic [4:0] bits);
      logic [7:0] res;
      case ({len, bits})
         {3'd2, 5'd1}:  res = 8'h80 | "A";
         {3'd4, 5'd8}:  res = 8'h80 | "B";
         {3'd4, 5'd10}: res = 8'h80 | "C";
         {3'd3, 5'd4}:  res = 8'h80 | "D";
         {3'd1, 5'd0}:  res = 8'h80 | "E";
         {3'd4, 5'd2}:  res = 8'h80 | "F";
         {3'd3, 5'd6}:  res = 8'h80 | "G";
         {3'd4, 5'd0}:  res = 8'h80 | "H";
         {3'd2, 5'd0}:  res = 8'h80 | "I";
         {3'd4, 5'd7}:  res = 8'h80 | "J";
         {3'd3, 5'd5}:  res = 8'h80 | "K";
         {3'd4, 5'd4}:  res = 8'h80 | "L";
         {3'd2, 5'd3}:  res = 8'h80 | "M";
         {3'd2, 5'd2}:  res = 8'h80 | "N";
         {3'd3, 5'd7}:  res = 8'h80 | "O";
         {3'd4, 5'd6}:  res = 8'h80 | "P";
         {3'd4, 5'd13}: res = 8'h80 | "Q";
         {3'd3, 5'd2}:  res = 8'h80 | "R";
         {3'd3, 5'd0}:  res = 8'h80 | "S";
         {3'd1, 5'd1}:  res = 8'h80 | "T";
         {3'd3, 5'd1}:  res = 8'h80 | "U";
         {3'd4, 5'd1}:  res = 8'h80 | "V";
         {3'd3, 5'd3}:  res = 8'h80 | "W";
         {3'd4, 5'd9}:  res = 8'h80 | "X";
         {3'd4, 5'd11}: res = 8'h80 | "Y";
         {3'd4, 5'd12}: res = 8'h80 | "Z";
         {3'd5, 5'd15}: res = 8'h80 | "1";
         {3'd5, 5'd7}:  res = 8'h80 | "2";
         {3'd5, 5'd3}:  res = 8'h80 | "3";
         {3'd5, 5'd1}:  res = 8'h80 | "4";
         {3'd5, 5'd0}:  res = 8'h80 | "5";
         {3'd5, 5'd16}: res = 8'h80 | "6";
         {3'd5, 5'd24}: res = 8'h80 | "7";
         {3'd5, 5'd28}: res = 8'h80 | "8";
         {3'd5, 5'd30}: res = 8'h80 | "9";
         {3'd5, 5'd31}: res = 8'h80 | "0";
         default:       res = 8'h00;
      endcase
      return res;
   endfunction

   function automatic void decode_symbol(input logic [2:0] sym);
      logic [7:0]      hit_char;
      char_result_type r;
      if (sym == SYM_DOT || sym == SYM_DASH) begin
         if (held_len < MAX_CODE_LEN_DEF) begin
            held_bits = {held_bits[3:0], sym[0]};
            held_len++;
         end else begin
            held_overflow = 1'b1;
         end
      end else if (sym == SYM_LETTER_GAP || sym == SYM_WORD_GAP || sym == SYM_END) begin
         if (held_len != 0 || held_overflow) begin
            hit_char = code_to_char(held_len, held_bits);
            r.ch = (held_overflow || !hit_char[7]) ? error_char_q : hit_char[6:0];
            r.last = (sym != SYM_WORD_GAP);
            expected_chars = {expected_chars, r};
         end
         if (sym == SYM_WORD_GAP) begin
            r.ch = SPACE_CHAR;
            r.last = 1'b1;
            expected_chars = {expected_chars, r};
         end
         held_bits = '0;
         held_len = '0;
         held_overflow = 1'b0;
      end
   endfunction

   function automatic void flag_error(input string what);
      fail_count++;
      if (fail_count <= 10) $display("mismatch: %s", what);
   endfunction

   always @(posedge clock) begin : check_results
      char_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_chars.size() == 0) begin
            flag_error($sformatf("unexpected item char %0d last %0b",
                                 rsp_out_char, rsp_last_of_run));
         end else begin
            want = expected_chars.pop_front();
            if (rsp_out_char !== want.ch)
               flag_error($sformatf("out_char exp %0d got %0d", want.ch, rsp_out_char));
            if (rsp_last_of_run !== want.last)
               flag_error($sformatf("last_of_run exp %0b got %0b", want.last, rsp_last_of_run));
         end
      end
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("status: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic send_symbol(input logic [2:0] sym);
      if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_symbol <= sym;
      do @(posedge clock); while (!req_ready);
      decode_symbol(sym);
   endtask

   // first symbol is the most significant of len bits; 1 is a dash
   task automatic send_code(input int len, input logic [7:0] bits);
      for (int i = len - 1; i >= 0; i--) send_symbol(bits[i] ? SYM_DASH : SYM_DOT);
   endtask

   task automatic wait_quiet();
      req_valid <= 1'b0;
      while (expected_chars.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_error_char(input logic [6:0] value);
      wait_quiet();
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      error_char_q = value;
   endtask

   task automatic test_known_codes();
      send_code(1, 8'b0);
      send_symbol(SYM_LETTER_GAP);
      send_code(5, 8'b11111);
      send_symbol(SYM_WORD_GAP);
   endtask

   task automatic test_bad_codes();
      send_code(4, 8'b0011);
      send_symbol(SYM_LETTER_GAP);
      send_code(6, 8'b111111);
      send_symbol(SYM_END);
   endtask

   task automatic test_empty_gaps();
      send_symbol(SYM_LETTER_GAP);
      send_symbol(SYM_WORD_GAP);
      send_symbol(SYM_END);
   endtask

   task automatic test_unused_symbols();
      send_symbol(SYM_DASH);
      for (int s = SYM_END + 1; s <= 7; s++) send_symbol(3'(s));
      send_symbol(SYM_WORD_GAP);
   endtask

   task automatic test_random_traffic(input int item_count);
      logic [2:0] closers [3];
      logic [2:0] sym;
      logic [7:0] bits;
      int sent;
      int len;
      closers = '{SYM_LETTER_GAP, SYM_WORD_GAP, SYM_END};
      sent = 0;
      while (sent < item_count) begin
         if ($urandom_range(99) < 80) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(8, 6) : $urandom_range(5, 1);
            bits = 8'($urandom);
            send_code(len, bits);
            send_symbol(closers[$urandom_range(2)]);
            sent += len + 1;
         end else begin
            sym = 3'($urandom_range(7));
            send_symbol(sym);
            if (sym <= SYM_END) sent++;
         end
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_known_codes();
      test_bad_codes();
      test_empty_gaps();
      test_unused_symbols();

      set_error_char(7'd127);
      send_idle_pct = 20;
      recv_idle_pct = 53;
      test_bad_codes();
      test_random_traffic(700);

      set_error_char(7'd0);
      send_idle_pct = 53;
      recv_idle_pct = 20;
      test_bad_codes();
      test_random_traffic(700);

      set_error_char(7'($urandom));
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_traffic(600);

      wait_quiet();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && expected_chars.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

FILE: morse_symbol_decoder_unit.f
rtl/msd_pkg.sv
rtl/msd_front.sv
rtl/msd_job_queue.sv
rtl/msd_back.sv
rtl/morse_symbol_decoder_unit.sv
tb/tb_morse_symbol_decoder_unit.sv
